@@ rtl/core/trde_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// trde_pkg
// Shared widths, field positions, opcode and ALU codes for the tiny RISC
// decode and execute block.
// ----------------------------------------------------------------------------
package trde_pkg;

    // widths
    localparam int INSTR_W      = 16;
    localparam int DATA_W       = 32;
    localparam int REG_FIELD_W  = 3;
    localparam int OPCODE_W     = 4;
    localparam int FUNCT_W      = 3;
    localparam int IMM_W        = 6;
    localparam int KIND_W       = 2;
    localparam int NUM_REGS_DEF = 8;

    // field positions in the instruction word
    localparam int OPCODE_LSB = 12;
    localparam int RS_LSB     = 9;
    localparam int RT_LSB     = 6;
    localparam int RD_LSB     = 3;

    // opcodes with a fixed meaning
    localparam logic [OPCODE_W-1:0] OPC_RTYPE = 4'h0;
    localparam logic [OPCODE_W-1:0] OPC_JMP0  = 4'h2;
    localparam logic [OPCODE_W-1:0] OPC_JMP1  = 4'h3;

    // ALU operation codes
    localparam logic [OPCODE_W-1:0] ALU_ADD = 4'h0;
    localparam logic [OPCODE_W-1:0] ALU_SUB = 4'h1;
    localparam logic [OPCODE_W-1:0] ALU_AND = 4'h2;
    localparam logic [OPCODE_W-1:0] ALU_OR  = 4'h3;

    // decoded instruction format
    typedef enum logic [KIND_W-1:0] {
        KIND_R = 2'd0,
        KIND_I = 2'd1,
        KIND_J = 2'd2
    } instr_kind_t;

endpackage : trde_pkg
`default_nettype wire

@@ rtl/core/trde_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// trde channel interfaces
// Valid/ready channels for instruction beats in and result beats out.
// ----------------------------------------------------------------------------
interface trde_in_if;
    logic                           valid;
    logic                           ready;
    logic [trde_pkg::INSTR_W-1:0]   instruction_word;

    modport source (output valid, output instruction_word, input ready);
    modport sink   (input valid, input instruction_word, output ready);
endinterface : trde_in_if

interface trde_out_if;
    logic                               valid;
    logic                               ready;
    logic [trde_pkg::KIND_W-1:0]        instr_kind;
    logic                               did_write;
    logic [trde_pkg::REG_FIELD_W-1:0]   dest_reg;
    logic signed [trde_pkg::DATA_W-1:0] write_value;
    logic                               bad_alu_op;

    modport source (output valid, output instr_kind, output did_write, output dest_reg,
                    output write_value, output bad_alu_op, input ready);
    modport sink   (input valid, input instr_kind, input did_write, input dest_reg,
                    input write_value, input bad_alu_op, output ready);
endinterface : trde_out_if
`default_nettype wire

@@ rtl/core/trde_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// trde_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read and read enable. Read during write returns old data.
// ----------------------------------------------------------------------------
module trde_ram #(
    parameter int WIDTH = trde_pkg::DATA_W,
    parameter int DEPTH = trde_pkg::NUM_REGS_DEF,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule : trde_ram
`default_nettype wire

@@ rtl/core/tiny_risc_decode_execute.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tiny_risc_decode_execute
// Decodes 16-bit instructions, reads an eight-entry register file held in
// two mirrored RAMs, runs a four-operation ALU and writes the result back.
// ----------------------------------------------------------------------------
//  channel  | dir | beat contents
//  ---------+-----+-----------------------------------------------------------
//  in_ch    | in  | instruction_word
//  out_ch   | out | instr_kind, did_write, dest_reg, write_value, bad_alu_op
//
//  one instruction per cycle sustained while the output does not stall; the
//  input beat is registered with its RAM read, then the ALU result is written
//  back and into the output register. A write back at the same edge as the next
//  read is forwarded. Reset clears the per-register valid bits, so an unwritten
//  register reads as zero at once; no clearing pass. A stalled output holds the
//  result and the execute stage; input stalls only when both are full.
// ----------------------------------------------------------------------------
module tiny_risc_decode_execute #(
    parameter int NUM_REGS = trde_pkg::NUM_REGS_DEF
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    trde_in_if.sink     in_ch,
    trde_out_if.source  out_ch
);

    localparam int IDX_W  = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
    localparam int DW     = trde_pkg::DATA_W;
    localparam int IW     = trde_pkg::INSTR_W;

    // input fields used for the register read
    logic [IDX_W-1:0] in_rs_idx;
    logic [IDX_W-1:0] in_rt_idx;
    logic             in_fire;

    // execute stage
    logic             s1_vld_reg;
    logic             s1_vld_next;
    logic [IW-1:0]    s1_word_reg;
    logic             a_byp_reg;
    logic             b_byp_reg;
    logic             a_live_reg;
    logic             b_live_reg;
    logic [DW-1:0]    byp_val_reg;
    logic [DW-1:0]    ram_a_data;
    logic [DW-1:0]    ram_b_data;

    // register valid bits
    logic [NUM_REGS-1:0] rv_reg;
    logic [NUM_REGS-1:0] rv_next;

    // output register
    logic                              out_vld_reg;
    logic                              out_vld_next;
    trde_pkg::instr_kind_t             out_kind_reg;
    logic                              out_wr_reg;
    logic [trde_pkg::REG_FIELD_W-1:0]  out_dest_reg;
    logic [DW-1:0]                     out_val_reg;
    logic                              out_bad_reg;

    // execute results
    logic [trde_pkg::OPCODE_W-1:0]     opcode;
    logic [trde_pkg::OPCODE_W-1:0]     alu_op;
    trde_pkg::instr_kind_t             kind;
    logic [trde_pkg::REG_FIELD_W-1:0]  dest;
    logic [DW-1:0]                     opnd_a;
    logic [DW-1:0]                     opnd_rt;
    logic [DW-1:0]                     opnd_b;
    logic [DW-1:0]                     alu_val;
    logic                              alu_bad;
    logic                              wrote;
    logic                              advance;
    logic                              wr_en;
    logic [IDX_W-1:0]                  wr_idx;

    // handshake
    assign advance   = s1_vld_reg && (!out_vld_reg || out_ch.ready);
    assign in_ch.ready = !s1_vld_reg || advance;
    assign in_fire   = in_ch.valid && in_ch.ready;
    assign in_rs_idx = in_ch.instruction_word[trde_pkg::RS_LSB +: IDX_W];
    assign in_rt_idx = in_ch.instruction_word[trde_pkg::RT_LSB +: IDX_W];

    // register file, one copy per read port
    trde_ram #(.WIDTH(DW), .DEPTH(NUM_REGS)) u_ram_a (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_idx),
        .wr_data (alu_val),
        .rd_en   (in_fire),
        .rd_addr (in_rs_idx),
        .rd_data (ram_a_data)
    );

    trde_ram #(.WIDTH(DW), .DEPTH(NUM_REGS)) u_ram_b (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_idx),
        .wr_data (alu_val),
        .rd_en   (in_fire),
        .rd_addr (in_rt_idx),
        .rd_data (ram_b_data)
    );

    // decode
    always_comb
    begin
        opcode = s1_word_reg[trde_pkg::OPCODE_LSB +: trde_pkg::OPCODE_W];
        unique case (opcode) inside
            trde_pkg::OPC_RTYPE:
            begin
                kind = trde_pkg::KIND_R;
            end
            trde_pkg::OPC_JMP0, trde_pkg::OPC_JMP1:
            begin
                kind = trde_pkg::KIND_J;
            end
            default:
            begin
                kind = trde_pkg::KIND_I;
            end
        endcase
    end

    // operand select with forwarding and unwritten-register zero
    always_comb
    begin
        if (a_byp_reg)
            opnd_a = byp_val_reg;
        else if (a_live_reg)
            opnd_a = ram_a_data;
        else
            opnd_a = '0;

        if (b_byp_reg)
            opnd_rt = byp_val_reg;
        else if (b_live_reg)
            opnd_rt = ram_b_data;
        else
            opnd_rt = '0;

        if (kind == trde_pkg::KIND_R)
        begin
            alu_op = {1'b0, s1_word_reg[trde_pkg::FUNCT_W-1:0]};
            opnd_b = opnd_rt;
            dest   = s1_word_reg[trde_pkg::RD_LSB +: trde_pkg::REG_FIELD_W];
        end
        else
        begin
            alu_op = opcode;
            opnd_b = {{(DW-trde_pkg::IMM_W){1'b0}}, s1_word_reg[trde_pkg::IMM_W-1:0]};
            dest   = s1_word_reg[trde_pkg::RT_LSB +: trde_pkg::REG_FIELD_W];
        end
    end

    // ALU
    always_comb
    begin
        alu_bad = 1'b0;
        unique case (alu_op)
            trde_pkg::ALU_ADD: alu_val = opnd_a + opnd_b;
            trde_pkg::ALU_SUB: alu_val = opnd_a - opnd_b;
            trde_pkg::ALU_AND: alu_val = opnd_a & opnd_b;
            trde_pkg::ALU_OR:  alu_val = opnd_a | opnd_b;
            default:
            begin
                alu_val = '0;
                alu_bad = 1'b1;
            end
        endcase
    end

    // write back
    assign wrote  = (kind != trde_pkg::KIND_J);
    assign wr_en  = advance && wrote;
    assign wr_idx = dest[IDX_W-1:0];

    always_comb
    begin
        rv_next = rv_reg;
        if (wr_en)
        begin
            rv_next[wr_idx] = 1'b1;
        end
    end

    // stage valids
    always_comb
    begin
        s1_vld_next = s1_vld_reg;
        if (in_fire)
            s1_vld_next = 1'b1;
        else if (advance)
            s1_vld_next = 1'b0;

        out_vld_next = out_vld_reg;
        if (advance)
            out_vld_next = 1'b1;
        else if (out_ch.ready)
            out_vld_next = 1'b0;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            rv_reg      <= '0;
        end
        else
        begin
            s1_vld_reg  <= s1_vld_next;
            out_vld_reg <= out_vld_next;
            rv_reg      <= rv_next;
        end
    end

    // execute stage payload, bypass captured against the write at this edge
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_word_reg <= in_ch.instruction_word;
            a_byp_reg   <= wr_en && (wr_idx == in_rs_idx);
            b_byp_reg   <= wr_en && (wr_idx == in_rt_idx);
            a_live_reg  <= rv_reg[in_rs_idx];
            b_live_reg  <= rv_reg[in_rt_idx];
            byp_val_reg <= alu_val;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_kind_reg <= kind;
            out_wr_reg   <= wrote;
            out_dest_reg <= wrote ? dest : '0;
            out_val_reg  <= wrote ? alu_val : '0;
            out_bad_reg  <= wrote && alu_bad;
        end
    end

    assign out_ch.valid       = out_vld_reg;
    assign out_ch.instr_kind  = out_kind_reg;
    assign out_ch.did_write   = out_wr_reg;
    assign out_ch.dest_reg    = out_dest_reg;
    assign out_ch.write_value = $signed(out_val_reg);
    assign out_ch.bad_alu_op  = out_bad_reg;

endmodule : tiny_risc_decode_execute
`default_nettype wire

@@ tb/tiny_risc_decode_execute_tb.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tiny_risc_decode_execute_tb
// Sends instruction beats through the input channel and checks each result
// beat against a shadow register file that executes the same instructions.
// Covers every format and ALU op, unknown ops, wrap-around and stalls on
// both channels.
// ----------------------------------------------------------------------------
module tiny_risc_decode_execute_tb;
    import trde_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int MAX_REPORTS = 10;

    // expected contents of one result beat
    typedef struct packed {
        instr_kind_t              kind;
        logic                     wrote;
        logic [REG_FIELD_W-1:0]   dest;
        logic [DATA_W-1:0]        value;
        logic                     bad;
    } exec_result_t;

    logic clk;
    logic rst_n;

    trde_in_if  in_ch ();
    trde_out_if out_ch ();

    tiny_risc_decode_execute dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    logic [DATA_W-1:0] shadow_regs [NUM_REGS_DEF];
    exec_result_t      pending_results [$];
    int                error_count      = 0;
    int                cycle_count      = 0;
    int                sink_hold_cycles = 0;
    bit                idle_on          = 1'b1;

    // clock
    initial clk = 1'b0;
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // execute one instruction on the shadow registers
    function automatic exec_result_t execute_word(input logic [INSTR_W-1:0] word);
        logic [OPCODE_W-1:0]    opc;
        logic [OPCODE_W-1:0]    op;
        logic [REG_FIELD_W-1:0] rs;
        logic [DATA_W-1:0]      a;
        logic [DATA_W-1:0]      b;
        exec_result_t           r;
        opc = word[OPCODE_LSB +: OPCODE_W];
        rs  = word[RS_LSB +: REG_FIELD_W];
        r   = '0;
        if (opc == OPC_JMP0 || opc == OPC_JMP1)
        begin
            r.kind = KIND_J;
            return r;
        end
        if (opc == OPC_RTYPE)
        begin
            r.kind = KIND_R;
            op     = OPCODE_W'(word[FUNCT_W-1:0]);
            b      = shadow_regs[word[RT_LSB +: REG_FIELD_W]];
            r.dest = word[RD_LSB +: REG_FIELD_W];
        end
        else
        begin
            // the opcode doubles as the alu op, immediate zero-extended
            r.kind = KIND_I;
            op     = opc;
            b      = DATA_W'(word[IMM_W-1:0]);
            r.dest = word[RT_LSB +: REG_FIELD_W];
        end
        a       = shadow_regs[rs];
        r.wrote = 1'b1;
        case (op)
            ALU_ADD: r.value = a + b;
            ALU_SUB: r.value = a - b;
            ALU_AND: r.value = a & b;
            ALU_OR:  r.value = a | b;
            default:
            begin
                r.value = '0;
                r.bad   = 1'b1;
            end
        endcase
        shadow_regs[r.dest] = r.value;
        return r;
    endfunction

    function automatic logic [INSTR_W-1:0] make_word(
        input logic [OPCODE_W-1:0]    opc,
        input logic [REG_FIELD_W-1:0] rs,
        input logic [REG_FIELD_W-1:0] rt,
        input logic [IMM_W-1:0]       low
    );
        return {opc, rs, rt, low};
    endfunction

    // mostly well-formed ops with random fields, the rest fully random
    function automatic logic [INSTR_W-1:0] random_word();
        logic [INSTR_W-1:0] word;
        int unsigned        pick;
        word = INSTR_W'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 45)
        begin
            word[OPCODE_LSB +: OPCODE_W] = OPC_RTYPE;
            word[FUNCT_W-1]              = 1'b0;
        end
        else if (pick < 70)
            word[OPCODE_LSB +: OPCODE_W] = ALU_SUB;
        else if (pick < 80)
            word[OPCODE_LSB +: OPCODE_W] = $urandom_range(0, 1) ? OPC_JMP1 : OPC_JMP0;
        return word;
    endfunction

    // send one instruction beat, with an optional idle burst before it
    task automatic send_beat(input logic [INSTR_W-1:0] word);
        if (idle_on && $urandom_range(0, 7) == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        in_ch.valid            <= 1'b1;
        in_ch.instruction_word <= word;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        pending_results.push_back(execute_word(word));
    endtask

    // stop sending and wait until every result beat is back
    task automatic drain_results();
        in_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // result sink: long hold-offs on request, random stall bursts otherwise
    initial
    begin
        out_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (sink_hold_cycles > 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (sink_hold_cycles) @(posedge clk);
                sink_hold_cycles = 0;
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge clk);
            end
            else
            begin
                out_ch.ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // compare each result beat with the oldest expected one
    always @(posedge clk)
    begin : check_beat
        exec_result_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (pending_results.size() == 0)
            begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                    $display("unexpected result beat: kind %0d wrote %0b dest %0d value %h bad %0b",
                             out_ch.instr_kind, out_ch.did_write, out_ch.dest_reg,
                             out_ch.write_value, out_ch.bad_alu_op);
            end
            else
            begin
                want = pending_results.pop_front();
                if (out_ch.instr_kind !== want.kind || out_ch.did_write !== want.wrote ||
                    out_ch.dest_reg !== want.dest || out_ch.write_value !== want.value ||
                    out_ch.bad_alu_op !== want.bad)
                begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                    begin
                        $display("mismatch exp: kind %0d wrote %0b dest %0d value %h bad %0b",
                                 want.kind, want.wrote, want.dest, want.value, want.bad);
                        $display("         got: kind %0d wrote %0b dest %0d value %h bad %0b",
                                 out_ch.instr_kind, out_ch.did_write, out_ch.dest_reg,
                                 out_ch.write_value, out_ch.bad_alu_op);
                    end
                end
            end
        end
    end

    // every format and op, unknown ops, wrap-around, all-zero and all-one words
    task automatic test_directed();
        send_beat(make_word(ALU_SUB, 3'd0, 3'd1, 6'd1));          // r1 = -1
        send_beat(make_word(ALU_SUB, 3'd0, 3'd2, 6'd63));         // r2 = -63
        send_beat(make_word(OPC_RTYPE, 3'd1, 3'd1, {3'd3, 3'd0})); // add wraps
        send_beat(make_word(OPC_RTYPE, 3'd2, 3'd1, {3'd4, 3'd1})); // sub
        send_beat(make_word(OPC_RTYPE, 3'd1, 3'd2, {3'd5, 3'd2})); // and
        send_beat(make_word(OPC_RTYPE, 3'd3, 3'd2, {3'd6, 3'd3})); // or
        // unknown funct still writes zero
        for (int f = 4; f < 8; f++)
            send_beat(make_word(OPC_RTYPE, 3'd7, 3'd6, {3'(f), 3'(f)}));
        // jumps with every other field set
        send_beat(make_word(OPC_JMP0, 3'd7, 3'd7, 6'h3F));
        send_beat(make_word(OPC_JMP1, 3'd7, 3'd7, 6'h3F));
        // unknown immediate ops, the last one is the all-ones word
        for (int op = 4; op < 16; op++)
            send_beat(make_word(4'(op), 3'd7, 3'(op), 6'h3F));
        send_beat('0);
        drain_results();
    endtask

    task automatic test_random_mix(input int count);
        for (int i = 0; i < count; i++)
            send_beat(random_word());
        drain_results();
    endtask

    // result side holds off while beats keep coming, so the input stalls
    task automatic test_output_hold();
        sink_hold_cycles = 300;
        for (int i = 0; i < 40; i++)
            send_beat(random_word());
        drain_results();
    endtask

    // sender pauses until every result is back, then resumes
    task automatic test_sender_pause();
        for (int p = 0; p < 2; p++)
        begin
            for (int i = 0; i < 20; i++)
                send_beat(random_word());
            drain_results();
        end
    endtask

    // main sequence
    initial
    begin
        rst_n                  = 1'b0;
        in_ch.valid            = 1'b0;
        in_ch.instruction_word = '0;
        for (int i = 0; i < NUM_REGS_DEF; i++)
            shadow_regs[i] = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_mix(900);
        test_output_hold();
        test_sender_pause();
        idle_on = 1'b0;
        test_random_mix(950);

        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule : tiny_risc_decode_execute_tb
`default_nettype wire
